FILE: hw/rtl/gssc_pkg.sv
`default_nettype none

package gssc_pkg;

    // Widths fixed by the item fields
    localparam int VERTEX_W       = 62;
    localparam int ROWNUM_W       = 6;
    localparam int ORDER_W        = 6;
    localparam int CNT_W          = 6;
    localparam int COUNT_W        = 48;
    // Order compare width, covers an order of up to 64
    localparam int N_W            = ORDER_W + 1;
    localparam int POP_LEAVES     = 64;

    localparam int MAX_ORDER_DFLT = 62;
    localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(62);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TEST  = 1'b1;

    typedef enum logic [2:0] {
        ST_WRITTEN = 3'd0,
        ST_BAD     = 3'd1,
        ST_IRREG   = 3'd2,
        ST_INADM   = 3'd3,
        ST_NOHALF  = 3'd4,
        ST_VALID   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_POP,
        CS_DEG,
        CS_CHK,
        CS_FIN
    } ctl_state_t;

    typedef struct packed {
        logic regular;
        logic admissible;
        logic has_half;
    } verdict_t;

    // Balanced adder tree, six levels deep
    function automatic logic [CNT_W-1:0] popcount(input logic [VERTEX_W-1:0] v);
        logic [CNT_W:0] acc [POP_LEAVES];
        for (int i = 0; i < POP_LEAVES; i++) begin
            acc[i] = '0;
        end
        for (int i = 0; i < VERTEX_W; i++) begin
            acc[i] = {{CNT_W{1'b0}}, v[i]};
        end
        for (int w = POP_LEAVES >> 1; w >= 1; w = w >> 1) begin
            for (int i = 0; i < w; i++) begin
                acc[i] = acc[2*i] + acc[2*i+1];
            end
        end
        return acc[0][CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gssc_lane.sv
`default_nettype none

module gssc_lane
    import gssc_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DFLT,
    parameter int LANE      = 0
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire logic [ROWNUM_W-1:0] wr_row,
    input  wire logic [VERTEX_W-1:0] wr_bits,
    input  wire logic                pop_en,
    input  wire logic [VERTEX_W-1:0] probe_set,
    output logic      [CNT_W-1:0]    cnt
);

    logic [VERTEX_W-1:0] keep;
    logic [VERTEX_W-1:0] row_reg;
    logic                row_valid_reg;
    logic [VERTEX_W-1:0] row_eff;
    logic [CNT_W-1:0]    cnt_reg;
    logic                wr_hit;

    // Drop the diagonal and any vertex beyond the maximum order
    always_comb
    begin
        for (int k = 0; k < VERTEX_W; k++) begin
            keep[k] = (k < MAX_ORDER) && (k != LANE);
        end
    end

    assign wr_hit  = wr_en && (wr_row == ROWNUM_W'(LANE));
    assign row_eff = row_valid_reg ? row_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_valid_reg <= 1'b0;
        end else if (wr_hit) begin
            row_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit) begin
            row_reg <= wr_bits & keep;
        end
        if (pop_en) begin
            cnt_reg <= popcount(row_eff & probe_set);
        end
    end

    assign cnt = cnt_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/gssc_merge.sv
`default_nettype none

module gssc_merge
    import gssc_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DFLT
)
(
    input  wire logic                              clk,
    input  wire logic                              deg_en,
    input  wire logic                              chk_en,
    input  wire logic [MAX_ORDER-1:0]              in_set,
    input  wire logic [MAX_ORDER-1:0]              outside,
    input  wire logic [MAX_ORDER-1:0][CNT_W-1:0]   lane_cnt,
    input  wire logic [CNT_W-1:0]                  set_size,
    output logic      [CNT_W-1:0]                  degree,
    output logic      [MAX_ORDER-1:0]              half_mask,
    output verdict_t                               verdict
);

    logic [MAX_ORDER-1:0] lowest;
    logic [CNT_W-1:0]     degree_sel;
    logic [CNT_W-1:0]     half_cnt;
    logic [MAX_ORDER-1:0] half_hit;
    logic [MAX_ORDER-1:0] out_ok;
    logic [MAX_ORDER-1:0] same_deg;

    logic [CNT_W-1:0]     degree_reg;
    logic [MAX_ORDER-1:0] half_hit_reg;
    logic [MAX_ORDER-1:0] out_ok_reg;
    verdict_t             verdict_reg;

    always_comb
    begin
        lowest     = in_set & (~in_set + MAX_ORDER'(1));
        half_cnt   = set_size >> 1;
        degree_sel = '0;
        for (int v = 0; v < MAX_ORDER; v++) begin
            if (lowest[v]) begin
                degree_sel = degree_sel | lane_cnt[v];
            end
            half_hit[v] = outside[v] && (lane_cnt[v] == half_cnt);
            out_ok[v]   = !outside[v] || (lane_cnt[v] == '0)
                          || (lane_cnt[v] == half_cnt) || (lane_cnt[v] == set_size);
            same_deg[v] = !in_set[v] || (lane_cnt[v] == degree_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (deg_en) begin
            degree_reg   <= degree_sel;
            half_hit_reg <= half_hit;
            out_ok_reg   <= out_ok;
        end
        if (chk_en) begin
            verdict_reg.regular    <= &same_deg;
            verdict_reg.admissible <= &out_ok_reg;
            verdict_reg.has_half   <= |half_hit_reg;
        end
    end

    assign degree    = degree_reg;
    assign half_mask = half_hit_reg;
    assign verdict   = verdict_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/graph_switching_set_checker.sv
// Switching set checker for an undirected graph of up to MAX_ORDER vertices.
//
// Input channel (in_valid/in_ready): an item with opcode write stores one
// adjacency row; an item with opcode test judges candidate_set. Every item
// gives exactly one result on the output channel (out_valid/out_ready).
// cfg_we/cfg_wdata set the order in use; write it only while the block idles.
//
// A write item goes from acceptance straight to the result step, and the next
// item may enter once the block is back in idle.
// A test item runs through the per-vertex lanes in four steps (popcount of the
// masked row, degree pick, regularity/admissibility reduction, result build),
// and no new item enters until its result is loaded and the block is idle again.
// There is one lane per vertex.
//
// Reset clears all rows (per-row valid bits), both counters and the output
// valid flag, and sets the order in use to 62. When the receiver stalls, the
// block still accepts one further item and works it up to the result step,
// then holds there until the output register is taken.
`default_nettype none

module graph_switching_set_checker
    import gssc_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DFLT
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [ORDER_W-1:0]  cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                opcode,
    input  wire logic [ROWNUM_W-1:0] row_number,
    input  wire logic [VERTEX_W-1:0] row_bits,
    input  wire logic [VERTEX_W-1:0] candidate_set,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [2:0]          status,
    output logic      [CNT_W-1:0]    set_degree,
    output logic      [VERTEX_W-1:0] half_mask,
    output logic      [COUNT_W-1:0]  examined_total,
    output logic      [COUNT_W-1:0]  valid_total
);

    // Control
    ctl_state_t           state_reg, state_next;
    logic                 accept;
    logic                 wr_en;
    logic                 pop_en, deg_en, chk_en, fin_go;

    // Item and configuration
    logic [ORDER_W-1:0]   order_reg;
    logic                 op_reg;
    logic [VERTEX_W-1:0]  set_reg;
    logic [CNT_W-1:0]     size_reg;
    logic                 bad_reg;

    // Set analysis
    logic [N_W-1:0]       n_sat;
    logic [CNT_W-1:0]     size_now;
    logic                 range_hit;
    logic                 bad_now;
    logic [MAX_ORDER-1:0] set_v;
    logic [MAX_ORDER-1:0] outside;
    logic [MAX_ORDER-1:0][CNT_W-1:0] lane_cnt;

    // Merge results
    logic [CNT_W-1:0]     merge_degree;
    logic [MAX_ORDER-1:0] merge_half;
    verdict_t             verdict;
    logic [VERTEX_W-1:0]  half_full;

    // Result and counters
    status_t              status_reg, status_next;
    logic [CNT_W-1:0]     degree_out_reg, degree_next;
    logic [VERTEX_W-1:0]  half_out_reg, half_next;
    logic                 out_valid_reg;
    logic [COUNT_W-1:0]   examined_reg, examined_next;
    logic [COUNT_W-1:0]   valid_cnt_reg, valid_cnt_next;

    assign accept = in_valid && in_ready;
    assign wr_en  = accept && (opcode == OP_WRITE);

    // Sequencer: next state and stage enables
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        pop_en     = 1'b0;
        deg_en     = 1'b0;
        chk_en     = 1'b0;
        fin_go     = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    state_next = (opcode == OP_TEST) ? CS_POP : CS_FIN;
                end
            end
            CS_POP:
            begin
                pop_en     = 1'b1;
                state_next = CS_DEG;
            end
            CS_DEG:
            begin
                deg_en     = 1'b1;
                state_next = CS_CHK;
            end
            CS_CHK:
            begin
                chk_en     = 1'b1;
                state_next = CS_FIN;
            end
            CS_FIN:
            begin
                // Hold here while the previous result still waits
                if (!out_valid_reg || out_ready) begin
                    fin_go     = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            order_reg <= ORDER_RESET;
        end else if (cfg_we) begin
            order_reg <= cfg_wdata;
        end
    end

    // Latch the item; the size test runs alongside the lane popcounts
    always_ff @(posedge clk)
    begin
        if (accept) begin
            op_reg  <= opcode;
            set_reg <= candidate_set;
        end
        if (pop_en) begin
            size_reg <= size_now;
            bad_reg  <= bad_now;
        end
    end

    // Saturate the order to the number of lanes
    assign n_sat = ({1'b0, order_reg} > N_W'(MAX_ORDER)) ? N_W'(MAX_ORDER)
                                                          : {1'b0, order_reg};

    always_comb
    begin
        size_now  = popcount(set_reg);
        range_hit = 1'b0;
        for (int i = 0; i < VERTEX_W; i++) begin
            if (set_reg[i] && (N_W'(i) >= n_sat)) begin
                range_hit = 1'b1;
            end
        end
        bad_now = (size_now < CNT_W'(2)) || size_now[0]
                  || ({1'b0, size_now} == n_sat) || range_hit;
    end

    // Map set membership onto the lanes
    for (genvar v = 0; v < MAX_ORDER; v++) begin : g_vert
        if (v < VERTEX_W) begin : g_in
            assign set_v[v] = set_reg[v];
        end else begin : g_out
            assign set_v[v] = 1'b0;
        end
        assign outside[v] = (N_W'(v) < n_sat) && !set_v[v];

        gssc_lane #(
            .MAX_ORDER (MAX_ORDER),
            .LANE      (v)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (wr_en),
            .wr_row    (row_number),
            .wr_bits   (row_bits),
            .pop_en    (pop_en),
            .probe_set (set_reg),
            .cnt       (lane_cnt[v])
        );
    end

    gssc_merge #(
        .MAX_ORDER (MAX_ORDER)
    ) u_merge (
        .clk       (clk),
        .deg_en    (deg_en),
        .chk_en    (chk_en),
        .in_set    (set_v),
        .outside   (outside),
        .lane_cnt  (lane_cnt),
        .set_size  (size_reg),
        .degree    (merge_degree),
        .half_mask (merge_half),
        .verdict   (verdict)
    );

    for (genvar i = 0; i < VERTEX_W; i++) begin : g_half
        if (i < MAX_ORDER) begin : g_live
            assign half_full[i] = merge_half[i];
        end else begin : g_dead
            assign half_full[i] = 1'b0;
        end
    end

    // Build the result and advance the counters
    always_comb
    begin
        status_next    = ST_WRITTEN;
        degree_next    = '0;
        half_next      = '0;
        examined_next  = examined_reg;
        valid_cnt_next = valid_cnt_reg;
        if (op_reg == OP_TEST) begin
            if (bad_reg) begin
                status_next = ST_BAD;
            end else begin
                examined_next = (examined_reg == COUNT_MAX) ? COUNT_MAX
                                                            : examined_reg + COUNT_W'(1);
                degree_next   = merge_degree;
                if (!verdict.regular) begin
                    status_next = ST_IRREG;
                end else if (!verdict.admissible) begin
                    status_next = ST_INADM;
                end else if (!verdict.has_half) begin
                    status_next = ST_NOHALF;
                end else begin
                    status_next    = ST_VALID;
                    half_next      = half_full;
                    valid_cnt_next = (valid_cnt_reg == COUNT_MAX) ? COUNT_MAX
                                                                  : valid_cnt_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            examined_reg  <= '0;
            valid_cnt_reg <= '0;
        end else begin
            if (fin_go) begin
                out_valid_reg <= 1'b1;
                examined_reg  <= examined_next;
                valid_cnt_reg <= valid_cnt_next;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go) begin
            status_reg     <= status_next;
            degree_out_reg <= degree_next;
            half_out_reg   <= half_next;
        end
    end

    // Counters only move when a result is loaded, so they track the output
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign set_degree     = degree_out_reg;
    assign half_mask      = half_out_reg;
    assign examined_total = examined_reg;
    assign valid_total    = valid_cnt_reg;

    a_valid_has_half: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status_reg == ST_VALID)) |-> (half_mask != '0))
        else $error("valid set reported with empty half mask");

    a_half_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status_reg != ST_VALID)) |-> (half_mask == '0))
        else $error("half mask set on a non-valid result");

    a_no_degree: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((status_reg == ST_WRITTEN) || (status_reg == ST_BAD)))
        |-> (set_degree == '0))
        else $error("degree reported for a write or rejected set");

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((valid_cnt_reg <= examined_reg)
                  && (examined_reg >= $past(examined_reg))))
        else $error("counter ordering broken");

endmodule

`default_nettype wire
